@@ hw/rtl/csrsp_pkg.sv @@
// shared types and constants of the csr sparse matrix-vector block
`default_nettype none

package csrsp_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_NZ    = 2'd1,
        REQ_CLOSE = 2'd2
    } t_req;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA = 2'd0,
        CFG_BETA  = 2'd1
    } t_cfg;

    localparam logic signed [31:0] ALPHA_RESET = 32'sd65536;
    localparam logic signed [31:0] BETA_RESET  = 32'sd0;

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // one item as it travels down the pipeline
    typedef struct packed {
        logic               valid;
        t_req               kind;
        logic               hit;   // column in store range, or row under the limit
        logic [15:0]        row;
        logic signed [31:0] yold;
    } t_item;

    typedef struct packed {
        logic [15:0]        row;
        logic signed [31:0] y;
        logic               sat;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/csrsp_xstore.sv @@
// dense vector store, one write and one registered read port
`default_nettype none

module csrsp_xstore #(
    parameter int X_DEPTH = 1024,
    parameter int AW      = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [31:0]       i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [31:0]       o_rdata
);

    logic [31:0] r_mem [X_DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/csrsp_mac.sv @@
// product stage and saturating row accumulator
`default_nettype none

module csrsp_mac (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire csrsp_pkg::t_item     i_item,
    input  wire logic signed [31:0]   i_data,
    input  wire logic signed [31:0]   i_x,
    output csrsp_pkg::t_item          o_item,
    output logic signed [63:0]        o_acc
);
    import csrsp_pkg::*;

    t_item              r_s1;
    logic signed [31:0] r_s1_data;
    t_item              r_s2;
    logic signed [63:0] r_s2_prod;
    t_item              r_s3;
    logic signed [63:0] r_s3_acc;
    logic signed [63:0] r_acc;
    logic signed [63:0] n_acc;
    logic signed [64:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= i_item;
        end
        r_s1_data <= i_data;
    end

    // x read data lines up with stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2 <= r_s1;
        end
        r_s2_prod <= 64'(r_s1_data) * 64'(i_x);
    end

    always_comb begin
        sum   = {r_acc[63], r_acc} + {r_s2_prod[63], r_s2_prod};
        n_acc = r_acc;
        if (r_s2.valid) begin
            case (r_s2.kind)
                REQ_NZ: begin
                    if (r_s2.hit) begin
                        if (sum[64] != sum[63]) begin
                            n_acc = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                        end else begin
                            n_acc = sum[63:0];
                        end
                    end
                end
                REQ_CLOSE: n_acc = '0;
                default:   n_acc = r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_s3.valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_s3  <= r_s2;
        end
        r_s3_acc <= r_acc;
    end

    assign o_item = r_s3;
    assign o_acc  = r_s3_acc;

endmodule

`default_nettype wire

@@ hw/rtl/csrsp_scale.sv @@
// row close: alpha*sum + beta*y_old, rounding and saturation
`default_nettype none

module csrsp_scale (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire csrsp_pkg::t_item     i_item,
    input  wire logic signed [63:0]   i_acc,
    input  wire logic signed [31:0]   i_alpha,
    input  wire logic signed [31:0]   i_beta,
    output logic                      o_push,
    output logic                      o_close_done,
    output csrsp_pkg::t_result        o_res
);
    import csrsp_pkg::*;

    t_item              r_s4;
    logic signed [64:0] r_plo;
    logic signed [63:0] r_phi;
    logic signed [63:0] r_pb;
    t_item              r_s5;
    logic signed [96:0] r_t;
    logic signed [96:0] r_u;
    t_item              r_s6;
    t_result            r_res;
    logic signed [96:0] s;
    t_result            n_res;

    // split the 64-bit sum into two halves so no product is wider than 33 by 32
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.valid <= 1'b0;
        end else begin
            r_s4 <= i_item;
        end
        r_plo <= 65'($signed({1'b0, i_acc[31:0]})) * 65'(i_alpha);
        r_phi <= 64'($signed(i_acc[63:32])) * 64'(i_alpha);
        r_pb  <= 64'(i_beta) * 64'(i_item.yold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.valid <= 1'b0;
        end else begin
            r_s5 <= r_s4;
        end
        r_t <= $signed({r_phi[63], r_phi, 32'd0}) + 97'(r_plo);
        // beta term moved up to the alpha term's scale, plus half for rounding
        r_u <= $signed({{17{r_pb[63]}}, r_pb, 16'd0}) + $signed(97'h0_8000_0000);
    end

    always_comb begin
        s         = r_t + r_u;
        n_res.row = r_s5.row;
        if ((&s[96:63]) || !(|s[96:63])) begin
            n_res.y   = s[63:32];
            n_res.sat = 1'b0;
        end else begin
            n_res.y   = s[96] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            n_res.sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6.valid <= 1'b0;
        end else begin
            r_s6 <= r_s5;
        end
        r_res <= n_res;
    end

    assign o_close_done = r_s6.valid && (r_s6.kind == REQ_CLOSE);
    assign o_push       = o_close_done && r_s6.hit;
    assign o_res        = r_res;

endmodule

`default_nettype wire

@@ hw/rtl/csrsp_outq.sv @@
// small result queue in front of the output channel
`default_nettype none

module csrsp_outq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire csrsp_pkg::t_result             i_res,
    input  wire logic                           i_pop,
    output logic                                o_valid,
    output csrsp_pkg::t_result                  o_res,
    output logic [csrsp_pkg::OUTQ_CNT_W-1:0]    o_count
);
    import csrsp_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);

    t_result               r_q [OUTQ_DEPTH];
    logic [PW-1:0]         r_wr;
    logic [PW-1:0]         r_rd;
    logic [OUTQ_CNT_W-1:0] r_cnt;
    logic                  pop;

    assign pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + OUTQ_CNT_W'(i_push) - OUTQ_CNT_W'(pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_q[r_rd];
    assign o_count = r_cnt;

endmodule

`default_nettype wire

@@ hw/rtl/csr_spmv_row_accumulate.sv @@
// top level of the csr sparse matrix-vector row accumulator
//
// Input stream (i_s_*): one request per transfer, its kind in tuser. Loads
// fill the x store, nonzeros multiply x[col] by the value into a 64-bit
// saturating row sum, a row close emits alpha*sum + beta*y_old rounded and
// saturated to Q16.16 and clears the sum.
// Output stream (o_m_*): one transfer per close whose row is under
// ROW_COUNT_MAX. Config channel (i_cfg_*): index 0 alpha, 1 beta, always
// ready; write it only while no request is in flight.
// Throughput: one request per cycle while ready is high. A close passes the
// store read stage, which loads on its transfer edge, then product,
// accumulate, two scaling stages, the result register and the output queue
// before it is offered on the output.
// Ready drops only when queued plus in-flight closes would fill the eight
// entry output queue, so a stalled receiver stops the input after about
// eight closes while loads and nonzeros ahead of them keep flowing.
// Reset clears the row sum, sets alpha to 1.0 and beta to 0, empties the
// pipeline and queue; the x store keeps whatever it held.
`default_nettype none

module csr_spmv_row_accumulate #(
    parameter int X_DEPTH       = 1024,
    parameter int ROW_COUNT_MAX = 65536
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // col_index[9:0], data_value[41:10], row_index[57:42], y_old[89:58], zero pad
    input  wire logic [95:0]                     i_s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                      i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // row_out[15:0], y_new[47:16]
    output logic [47:0]                          o_m_tdata,
    // saturated[0]
    output logic [0:0]                           o_m_tuser,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [csrsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data
);
    import csrsp_pkg::*;

    localparam int AW = $clog2(X_DEPTH);

    logic                  accept;
    t_item                 s0_item;
    logic [9:0]            col;
    logic [16:0]           col_ext;
    logic [AW-1:0]         addr;
    logic signed [31:0]    data;
    logic                  col_ok;
    logic                  row_ok;
    logic signed [31:0]    x_rd;
    t_item                 s3_item;
    logic signed [63:0]    s3_acc;
    logic                  push;
    logic                  close_done;
    t_result               res;
    t_result               q_res;
    logic [OUTQ_CNT_W-1:0] q_cnt;
    logic [OUTQ_CNT_W-1:0] r_inflight;
    logic signed [31:0]    r_alpha;
    logic signed [31:0]    r_beta;

    assign col     = i_s_tdata[9:0];
    assign data    = i_s_tdata[41:10];
    assign col_ext = 17'(col);
    assign addr    = col_ext[AW-1:0];
    assign col_ok  = col_ext < 17'(X_DEPTH);
    assign row_ok  = 25'(i_s_tdata[57:42]) < 25'(ROW_COUNT_MAX);

    assign o_s_tready = ({1'b0, q_cnt} + {1'b0, r_inflight}) < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        s0_item.valid = accept;
        s0_item.kind  = t_req'(i_s_tuser);
        s0_item.hit   = (t_req'(i_s_tuser) == REQ_CLOSE) ? row_ok : col_ok;
        s0_item.row   = i_s_tdata[57:42];
        s0_item.yold  = i_s_tdata[89:58];
    end

    // closes between the input and the queue, reserved against queue space
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight
                        + OUTQ_CNT_W'(accept && (t_req'(i_s_tuser) == REQ_CLOSE))
                        - OUTQ_CNT_W'(close_done);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_beta  <= BETA_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg'(i_cfg_index))
                CFG_ALPHA: r_alpha <= i_cfg_data;
                CFG_BETA:  r_beta  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    csrsp_xstore #(
        .X_DEPTH (X_DEPTH),
        .AW      (AW)
    ) u_xstore (
        .i_clk   (i_clk),
        .i_we    (accept && col_ok && (t_req'(i_s_tuser) == REQ_LOAD)),
        .i_waddr (addr),
        .i_wdata (data),
        .i_re    (accept && col_ok && (t_req'(i_s_tuser) == REQ_NZ)),
        .i_raddr (addr),
        .o_rdata (x_rd)
    );

    csrsp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (s0_item),
        .i_data  (data),
        .i_x     (x_rd),
        .o_item  (s3_item),
        .o_acc   (s3_acc)
    );

    csrsp_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (s3_item),
        .i_acc        (s3_acc),
        .i_alpha      (r_alpha),
        .i_beta       (r_beta),
        .o_push       (push),
        .o_close_done (close_done),
        .o_res        (res)
    );

    csrsp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_res   (q_res),
        .o_count (q_cnt)
    );

    assign o_m_tdata = {q_res.y, q_res.row};
    assign o_m_tuser = q_res.sat;

endmodule

`default_nettype wire

@@ hw/rtl/csrsp_checker.sv @@
// port-level checks for the row accumulator, bound to the top level
`default_nettype none

module csrsp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [47:0] o_m_tdata,
    input  wire logic [0:0]  o_m_tuser
);

    // a result stays offered until the transfer
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result withdrawn before transfer");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // a clipped result sits exactly on one of the two limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            (o_m_tdata[47:16] == 32'h7fff_ffff) || (o_m_tdata[47:16] == 32'h8000_0000))
        else $error("saturation flag without limit value");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered straight after reset");

endmodule

bind csr_spmv_row_accumulate csrsp_checker u_csrsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

@@ verif/tb_csr_spmv_row_accumulate.sv @@
// self-checking testbench for the csr sparse matrix-vector row accumulator
module tb_csr_spmv_row_accumulate;
    timeunit 1ns;
    timeprecision 1ps;

    import csrsp_pkg::*;

    localparam int X_SIZE      = 1024;
    localparam int ROW_LIMIT   = 65536;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 155;
    localparam int DRAIN_WAIT  = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [127:0] ROUND_HALF = 128'sh8000_0000;
    localparam logic signed [127:0] Y_MAX      = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] Y_MIN      = -128'sh8000_0000;
    localparam logic signed [63:0]  SUM_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]  SUM_MIN    = 64'sh8000_0000_0000_0000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [95:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [47:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        o_cfg_ready;

    // both sides run without gaps while set
    bit no_idle  = 1'b0;
    // asks the result side for one long hold-off
    bit hold_req = 1'b0;

    bit       x_written [X_SIZE];
    logic [9:0] x_cols [$];
    logic [31:0] alpha_set [N_PHASES] = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000};
    logic [31:0] beta_set  [N_PHASES] = '{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h0001_0000, 32'h0000_0000, 32'h0000_8000};

    csr_spmv_row_accumulate dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // tracks the x vector and row sum, and holds the row results still due
    class row_sum_tracker;
        logic signed [31:0] alpha_q;
        logic signed [31:0] beta_q;
        logic signed [31:0] x_mem [X_SIZE];
        logic signed [63:0] row_sum;
        t_result            due [$];
        int                 fails;

        function new();
            alpha_q = ALPHA_RESET;
            beta_q  = BETA_RESET;
            row_sum = '0;
            fails   = 0;
        endfunction

        function void set_scale(t_cfg idx, logic [31:0] v);
            case (idx)
                CFG_ALPHA: alpha_q = v;
                CFG_BETA:  beta_q = v;
                default: ;
            endcase
        endfunction

        function void take_request(logic [1:0] kind, logic [9:0] col, logic signed [31:0] val,
                                   logic [15:0] row, logic signed [31:0] yold);
            logic signed [63:0]  prod;
            logic signed [63:0]  sum64;
            logic signed [63:0]  beta_y;
            logic signed [127:0] sum_w;
            logic signed [127:0] alpha_w;
            logic signed [127:0] tail;
            logic signed [127:0] total;
            logic signed [127:0] shifted;
            t_result             want;
            case (kind)
                REQ_LOAD: begin
                    if (int'(col) < X_SIZE) x_mem[col] = val;
                end
                REQ_NZ: begin
                    if (int'(col) < X_SIZE) begin
                        prod  = 64'(val) * 64'(x_mem[col]);
                        sum64 = row_sum + prod;
                        // row sum clips at the 64-bit limits
                        if (!row_sum[63] && !prod[63] && sum64[63]) sum64 = SUM_MAX;
                        else if (row_sum[63] && prod[63] && !sum64[63]) sum64 = SUM_MIN;
                        row_sum = sum64;
                    end
                end
                REQ_CLOSE: begin
                    sum_w   = 128'(row_sum);
                    alpha_w = 128'(alpha_q);
                    beta_y  = 64'(beta_q) * 64'(yold);
                    tail    = 128'(beta_y);
                    tail    = tail <<< 16;
                    total   = sum_w * alpha_w + tail + ROUND_HALF;
                    shifted = total >>> 32;
                    row_sum = '0;
                    if (int'(row) < ROW_LIMIT) begin
                        want.row = row;
                        if (shifted > Y_MAX) begin
                            want.y   = 32'h7FFF_FFFF;
                            want.sat = 1'b1;
                        end else if (shifted < Y_MIN) begin
                            want.y   = 32'h8000_0000;
                            want.sat = 1'b1;
                        end else begin
                            want.y   = shifted[31:0];
                            want.sat = 1'b0;
                        end
                        due.push_back(want);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_row_result(logic [15:0] row, logic signed [31:0] y, logic sat);
            t_result want;
            if (due.size() == 0) begin
                $error("result for row %0d with no close waiting", row);
                fails++;
                return;
            end
            want = due.pop_front();
            if (row !== want.row) begin
                $error("row_out: expected %0d, got %0d", want.row, row);
                fails++;
            end
            if (y !== want.y) begin
                $error("y_new: expected %0d, got %0d", $signed(want.y), y);
                fails++;
            end
            if (sat !== want.sat) begin
                $error("saturated: expected %0d, got %0d", want.sat, sat);
                fails++;
            end
        endfunction
    endclass

    row_sum_tracker book;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [31:0] pick_value();
        logic [17:0] r;
        r = 18'($urandom);
        case ($urandom_range(9))
            0:       pick_value = 32'h7FFF_FFFF;
            1:       pick_value = 32'h8000_0000;
            2, 3, 4: pick_value = {{14{r[17]}}, r};
            default: pick_value = $urandom;
        endcase
    endfunction

    // only columns already loaded, so no unwritten x entry is ever read
    function automatic logic [9:0] pick_col();
        pick_col = x_cols[$urandom_range(x_cols.size() - 1)];
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [9:0] col,
                             input logic [31:0] val, input logic [15:0] row,
                             input logic [31:0] yold);
        if (!no_idle && $urandom_range(99) < 23) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 23);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {6'd0, yold, row, val, col};
        do @(posedge i_clk); while (!o_s_tready);
        book.take_request(kind, col, val, row, yold);
        if (kind == REQ_LOAD && !x_written[col]) begin
            x_written[col] = 1'b1;
            x_cols.push_back(col);
        end
    endtask

    task automatic write_reg(input t_cfg idx, input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.set_scale(idx, v);
    endtask

    task automatic write_scales(input logic [31:0] a, input logic [31:0] b);
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_BETA, b);
        i_cfg_valid <= 1'b0;
    endtask

    // loads and nonzeros give no result, so allow the pipeline to empty as well
    task automatic wait_drained();
        while (book.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_item(REQ_LOAD, 10'd0, 32'h7FFF_FFFF, 16'h0000, 32'h0);
        send_item(REQ_LOAD, 10'd1023, 32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(REQ_LOAD, 10'd5, 32'h0001_0000, 16'h0, 32'h0);
        send_item(REQ_LOAD, 10'd6, 32'hFFFF_0000, 16'h0, 32'h0);
        send_item(REQ_LOAD, 10'h2AA, 32'h5555_5555, 16'h5555, 32'h5555_5555);
        send_item(REQ_LOAD, 10'h155, 32'hAAAA_AAAA, 16'hAAAA, 32'hAAAA_AAAA);
        // empty row
        send_item(REQ_CLOSE, 10'd5, 32'h0, 16'd1, 32'h0001_2345);
        send_item(REQ_NZ, 10'd5, 32'h0003_0000, 16'h0, 32'h0);
        send_item(REQ_NZ, 10'd6, 32'h0000_8000, 16'h0, 32'h0);
        send_item(REQ_CLOSE, 10'd5, 32'h0, 16'hFFFF, 32'h7FFF_FFFF);
        // row sum runs past the positive 64-bit limit
        repeat (3) send_item(REQ_NZ, 10'd1023, 32'h8000_0000, 16'h0, 32'h0);
        send_item(REQ_CLOSE, 10'd1023, 32'h0, 16'h0000, 32'h8000_0000);
        // and past the negative one
        repeat (3) send_item(REQ_NZ, 10'd0, 32'h8000_0000, 16'h0, 32'h0);
        send_item(REQ_CLOSE, 10'd0, 32'h0, 16'h5555, 32'h0);
        send_item(REQ_UNUSED, 10'h2AA, 32'h7FFF_FFFF, 16'hAAAA, 32'h7FFF_FFFF);
        // tiny product, lands on the rounding step
        send_item(REQ_NZ, 10'h2AA, 32'h0000_0001, 16'h0, 32'h0);
        send_item(REQ_CLOSE, 10'h2AA, 32'h0, 16'hAAAA, 32'h0);
        send_item(REQ_NZ, 10'h155, 32'h7FFF_FFFF, 16'h0, 32'h0);
        send_item(REQ_CLOSE, 10'h155, 32'h0, 16'd2, 32'h7FFF_FFFF);
    endtask

    // well-formed rows with random content, loads and unused requests mixed in
    task automatic run_rows(input int budget);
        int sent;
        int n;
        sent = 0;
        while (sent < budget) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(9) == 0) begin
                    send_item(REQ_LOAD, 10'($urandom_range(1023)), pick_value(),
                              16'($urandom), 32'($urandom));
                    sent++;
                end
                send_item(REQ_NZ, pick_col(), pick_value(), 16'($urandom), 32'($urandom));
                sent++;
                if ($urandom_range(39) == 0)
                    send_item(REQ_UNUSED, pick_col(), 32'($urandom), 16'($urandom),
                              32'($urandom));
            end
            send_item(REQ_CLOSE, pick_col(), 32'($urandom), 16'($urandom_range(65535)),
                      pick_value());
            sent++;
        end
    endtask

    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                book.check_row_result(o_m_tdata[15:0], o_m_tdata[47:16], o_m_tuser[0]);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_tready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        book = new();
        alpha_set[4] = $urandom;
        beta_set[4]  = $urandom;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_rows(PHASE_ITEMS);
        for (int p = 0; p < N_PHASES; p++) begin
            i_s_tvalid <= 1'b0;
            wait_drained();
            write_scales(alpha_set[p], beta_set[p]);
            no_idle = (p == 1);
            // result side stalls long enough for the output queue to fill
            if (p == 2) hold_req = 1'b1;
            run_rows(PHASE_ITEMS);
        end
        i_s_tvalid <= 1'b0;
        no_idle = 1'b0;
        wait_drained();
        if (book.fails == 0 && book.due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
